[hw/rtl/zse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_pkg
// Types, codes and constants shared by the zonal statistics engine.
// ----------------------------------------------------------------------------
package zse_pkg;

    // default table size
    localparam int DEF_NUM_ZONES = 1024;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // item kinds
    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_LOOK = 2'd1;
    localparam logic [1:0] KIND_CLR  = 2'd2;

    // statistic selector codes
    localparam logic [2:0] STAT_SUM   = 3'd0;
    localparam logic [2:0] STAT_MEAN  = 3'd1;
    localparam logic [2:0] STAT_MIN   = 3'd2;
    localparam logic [2:0] STAT_MAX   = 3'd3;
    localparam logic [2:0] STAT_COUNT = 3'd4;
    localparam logic [2:0] STAT_NZ    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_STAT_SELECT  = 2'd0;
    localparam logic [1:0] CFG_ZONE_NODATA  = 2'd1;
    localparam logic [1:0] CFG_VALUE_NODATA = 2'd2;

    // reset values of the configuration registers
    localparam logic [2:0]         RST_STAT_SELECT  = STAT_SUM;
    localparam logic [15:0]        RST_ZONE_NODATA  = 16'hFFFF;
    localparam logic signed [31:0] RST_VALUE_NODATA = 32'sh8000_0000;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [31:0]        CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        zone_id;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [63:0] stat_value;
        logic               is_nodata;
        logic               zone_out_of_range;
    } t_result;

    // work classified by the front part
    typedef enum logic [2:0] {
        OP_ACC,
        OP_LOOK,
        OP_CLR,
        OP_NODATA,
        OP_OOR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [15:0]        zone;
        logic signed [31:0] value;
    } t_qent;

    // one zone entry of the table
    typedef struct packed {
        logic [31:0]        cnt;
        logic [31:0]        nz;
        logic signed [63:0] sum;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{
        cnt: 32'd0,
        nz:  32'd0,
        sum: 64'sd0,
        mn:  32'sh7FFF_FFFF,
        mx:  32'sh8000_0000
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    // back part status seen by the top level
    typedef struct packed {
        logic init_busy;
        logic div_busy;
    } t_back_status;

endpackage

[hw/rtl/zse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module zse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/zse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_front
// Accepts items, classifies them against the nodata registers and the table
// size, and queues the work for the back part.
// ----------------------------------------------------------------------------
module zse_front #(
    parameter int NUM_ZONES = zse_pkg::DEF_NUM_ZONES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  zse_pkg::t_item      i_item,
    input  logic [15:0]         i_zone_nodata,
    input  logic signed [31:0]  i_value_nodata,
    input  logic                i_hold,
    output logic                o_q_valid,
    output zse_pkg::t_qent      o_q_data,
    input  logic                i_q_pop
);
    import zse_pkg::*;

    t_qent             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wp;
    logic [Q_AW-1:0]   n_rp;
    logic [Q_AW:0]     n_cnt;
    logic              w_accept;
    logic              w_nodata;
    logic              w_oor;
    logic              w_enq;
    logic              w_deq;
    t_qent             w_ent;

    assign full     = (r_cnt == (Q_AW+1)'(Q_DEPTH)) || i_hold;
    assign w_accept = push && !full;

    // classify the incoming item
    always_comb begin
        w_nodata = (i_item.zone_id == i_zone_nodata) || (i_item.value == i_value_nodata);
        w_oor    = {1'b0, i_item.zone_id} >= 17'(NUM_ZONES);
        w_ent.zone  = i_item.zone_id;
        w_ent.value = i_item.value;
        w_ent.op    = OP_ACC;
        w_enq       = 1'b0;
        case (i_item.kind)
            KIND_ACC: begin
                w_enq    = !w_nodata;
                w_ent.op = w_oor ? OP_OOR : OP_ACC;
            end
            KIND_LOOK: begin
                w_enq    = 1'b1;
                w_ent.op = w_nodata ? OP_NODATA : (w_oor ? OP_OOR : OP_LOOK);
            end
            KIND_CLR: begin
                w_enq    = 1'b1;
                w_ent.op = w_oor ? OP_OOR : OP_CLR;
            end
            default: begin
                w_enq = 1'b0;
            end
        endcase
    end

    assign w_deq     = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rp];

    // queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_accept && w_enq) begin
            n_wp = r_wp + 1'b1;
        end
        if (w_deq) begin
            n_rp = r_rp + 1'b1;
        end
        if ((w_accept && w_enq) && !w_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!(w_accept && w_enq) && w_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept && w_enq) begin
            r_mem[r_wp] <= w_ent;
        end
    end

endmodule

[hw/rtl/zse_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_div
// Signed 64-bit by unsigned 32-bit divider, truncating toward zero, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module zse_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic [31:0]        i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quotient
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_dsr;
    logic        r_neg;
    logic [32:0] w_sh;
    logic        w_ge;
    logic [32:0] w_diff;

    // one restoring step
    assign w_sh   = {r_rem, r_q[63]};
    assign w_ge   = w_sh >= {1'b0, r_dsr};
    assign w_diff = w_sh - {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'h3F);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'h3F) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_q   <= i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

[hw/rtl/zse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zse_back
// Carries out queued work on the zone table: clearing pass after reset,
// read-modify-write for accumulates, lookups with the mean divider, and the
// result register toward the output side.
// ----------------------------------------------------------------------------
module zse_back #(
    parameter int NUM_ZONES = zse_pkg::DEF_NUM_ZONES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_stat_select,
    input  logic                  i_q_valid,
    input  zse_pkg::t_qent        i_q_data,
    output logic                  o_q_pop,
    output logic                  empty,
    input  logic                  pop,
    output zse_pkg::t_result      o_result,
    output zse_pkg::t_back_status o_status
);
    import zse_pkg::*;

    localparam int ZW = $clog2(NUM_ZONES);

    t_state             r_state;
    t_state             n_state;
    logic [ZW-1:0]      r_clr_idx;
    logic [ZW-1:0]      n_clr_idx;
    t_qent              r_cur;
    t_result            r_res;
    t_result            n_res;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_out;
    logic               w_load_out;
    logic               w_we;
    logic [ZW-1:0]      w_waddr;
    t_entry             w_wdata;
    logic [ZW-1:0]      w_raddr;
    logic [$bits(t_entry)-1:0] w_rdata_raw;
    t_entry             w_rd;
    t_entry             w_acc;
    logic signed [63:0] w_vx;
    logic signed [63:0] w_add;
    logic               w_div_start;
    logic               w_div_done;
    logic signed [63:0] w_quot;

    // zone table
    zse_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_ZONES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd    = t_entry'(w_rdata_raw);
    assign w_raddr = i_q_data.zone[ZW-1:0];

    // mean divider
    zse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rd.sum),
        .i_divisor  (w_rd.cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // accumulate update with saturation
    always_comb begin
        w_vx  = 64'(r_cur.value);
        w_add = w_rd.sum + w_vx;
        w_acc = w_rd;
        if (w_rd.cnt != CNT_MAX) begin
            w_acc.cnt = w_rd.cnt + 32'd1;
        end
        if ((r_cur.value != 32'sd0) && (w_rd.nz != CNT_MAX)) begin
            w_acc.nz = w_rd.nz + 32'd1;
        end
        if ((w_rd.sum[63] == w_vx[63]) && (w_add[63] != w_rd.sum[63])) begin
            w_acc.sum = w_vx[63] ? SUM_MIN : SUM_MAX;
        end else begin
            w_acc.sum = w_add;
        end
        if (r_cur.value < w_rd.mn) begin
            w_acc.mn = r_cur.value;
        end
        if (r_cur.value > w_rd.mx) begin
            w_acc.mx = r_cur.value;
        end
    end

    assign w_load_out = !r_out_valid || pop;

    // sequencer: next state, table writes and result
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_cur.zone[ZW-1:0];
        w_wdata     = RESET_ENTRY;
        w_div_start = 1'b0;
        n_out_valid = r_out_valid && !pop;
        case (r_state)
            ST_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == ZW'(NUM_ZONES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res.is_nodata         = 1'b0;
                n_res.zone_out_of_range = 1'b0;
                n_res.stat_value        = '0;
                n_state                 = ST_OUT;
                case (r_cur.op)
                    OP_ACC: begin
                        w_we    = 1'b1;
                        w_wdata = w_acc;
                        n_state = ST_IDLE;
                    end
                    OP_CLR: begin
                        w_we    = 1'b1;
                        n_state = ST_IDLE;
                    end
                    OP_NODATA: begin
                        n_res.is_nodata = 1'b1;
                    end
                    OP_OOR: begin
                        n_res.zone_out_of_range = 1'b1;
                    end
                    OP_LOOK: begin
                        case (i_stat_select)
                            STAT_SUM:   n_res.stat_value = w_rd.sum;
                            STAT_MEAN: begin
                                if (w_rd.cnt != 32'd0) begin
                                    w_div_start = 1'b1;
                                    n_state     = ST_DIV;
                                end
                            end
                            STAT_MIN:   n_res.stat_value = 64'(w_rd.mn);
                            STAT_MAX:   n_res.stat_value = 64'(w_rd.mx);
                            STAT_COUNT: n_res.stat_value = $signed({32'd0, w_rd.cnt});
                            STAT_NZ:    n_res.stat_value = $signed({32'd0, w_rd.nz});
                            default:    n_res.stat_value = '0;
                        endcase
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res.stat_value = w_quot;
                    n_state          = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        if ((r_state == ST_OUT) && w_load_out) begin
            r_out <= r_res;
        end
    end

    assign empty              = !r_out_valid;
    assign o_result           = r_out;
    assign o_status.init_busy = (r_state == ST_CLEAR);
    assign o_status.div_busy  = (r_state == ST_DIV);

endmodule

[hw/rtl/zonal_statistics_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zonal_statistics_engine
// Per-zone count, non-zero count, sum, min and max over a pixel stream, with
// lookups of a selected statistic.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter through push/full as a queue; an accepted item is classified
//   at once and parked in a 4-entry queue. Results leave through empty/pop;
//   the oldest result sits on o_result while empty is low.
//   Configuration writes use i_cfg_valid/o_cfg_ready (always ready) with the
//   register index on i_cfg_index; write only while the block is idle.
//   Throughput is set by the back part's table port, one item at a time:
//   accumulate and clear pass through the idle and execute states, nodata,
//   out-of-range and other lookups also through the output state, and a mean
//   with a non-zero count waits in the divide state too, since the divider
//   yields one quotient bit per cycle. Nodata accumulates and unused kinds
//   are dropped in the front and cost no back time.
//   After reset the table is swept back to its empty contents, one zone per
//   cycle; full stays high during the sweep.
//   A result that is not popped holds the back part in place; the front
//   queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module zonal_statistics_engine #(
    parameter int NUM_ZONES = zse_pkg::DEF_NUM_ZONES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  zse_pkg::t_item    i_item,
    output logic              empty,
    input  logic              pop,
    output zse_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import zse_pkg::*;

    logic [2:0]         r_stat_select;
    logic [15:0]        r_zone_nodata;
    logic signed [31:0] r_value_nodata;
    logic               w_q_valid;
    t_qent              w_q_data;
    logic               w_q_pop;
    t_back_status       w_status;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_select  <= RST_STAT_SELECT;
            r_zone_nodata  <= RST_ZONE_NODATA;
            r_value_nodata <= RST_VALUE_NODATA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STAT_SELECT:  r_stat_select  <= i_cfg_data[2:0];
                CFG_ZONE_NODATA:  r_zone_nodata  <= i_cfg_data[15:0];
                CFG_VALUE_NODATA: r_value_nodata <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    zse_front #(
        .NUM_ZONES (NUM_ZONES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_item         (i_item),
        .i_zone_nodata  (r_zone_nodata),
        .i_value_nodata (r_value_nodata),
        .i_hold         (w_status.init_busy),
        .o_q_valid      (w_q_valid),
        .o_q_data       (w_q_data),
        .i_q_pop        (w_q_pop)
    );

    // back: table work and results
    zse_back #(
        .NUM_ZONES (NUM_ZONES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat_select (r_stat_select),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .o_status      (w_status)
    );

    // no transfer in while the table is being swept
    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.init_busy |-> full)
        else $error("item accepted during table sweep");

    // the divider only runs after the sweep
    a_div_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_busy |-> !w_status.init_busy)
        else $error("divider busy during table sweep");

    // back takes queued work only when the queue has some
    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zonal statistics engine: items are pushed with
// random gaps, results are popped with random stalls, and each result is
// compared against a per-zone statistics table kept in the bench.
// ----------------------------------------------------------------------------
import zse_pkg::*;

// zone table predictor and queue of pending statistics
class zone_stats_board;
    logic [31:0]        cnt [DEF_NUM_ZONES];
    logic [31:0]        nzc [DEF_NUM_ZONES];
    logic signed [63:0] sum [DEF_NUM_ZONES];
    logic signed [31:0] mn  [DEF_NUM_ZONES];
    logic signed [31:0] mx  [DEF_NUM_ZONES];
    logic [2:0]         sel;
    logic [15:0]        zone_nd;
    logic signed [31:0] value_nd;
    t_result            pending [$];
    int                 errors;
    int                 checked;

    function new();
        sel      = RST_STAT_SELECT;
        zone_nd  = RST_ZONE_NODATA;
        value_nd = RST_VALUE_NODATA;
        errors   = 0;
        checked  = 0;
        for (int z = 0; z < DEF_NUM_ZONES; z++) wipe(z);
    endfunction

    function void wipe(int z);
        cnt[z] = 32'd0;
        nzc[z] = 32'd0;
        sum[z] = 64'sd0;
        mn[z]  = 32'sh7FFF_FFFF;
        mx[z]  = 32'sh8000_0000;
    endfunction

    // append an expected result at the tail
    function void queue_result(t_result r);
        pending.insert(pending.size(), r);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            CFG_STAT_SELECT:  sel = data[2:0];
            CFG_ZONE_NODATA:  zone_nd = data[15:0];
            CFG_VALUE_NODATA: value_nd = data;
            default: ;
        endcase
    endfunction

    // fold one accepted item into the table, queue any result
    function void note_item(t_item it);
        t_result            r;
        logic               nd;
        logic signed [64:0] wide;
        int                 z;
        nd = (it.zone_id == zone_nd) || (it.value == value_nd);
        z  = it.zone_id;
        r  = '0;
        if (it.kind == 2'd3) return;
        if (it.kind == KIND_LOOK && nd) begin
            r.is_nodata = 1'b1;
            queue_result(r);
            return;
        end
        if (it.kind == KIND_ACC && nd) return;
        if (z >= DEF_NUM_ZONES) begin
            r.zone_out_of_range = 1'b1;
            queue_result(r);
            return;
        end
        if (it.kind == KIND_CLR) begin
            wipe(z);
            return;
        end
        if (it.kind == KIND_ACC) begin
            if (cnt[z] != CNT_MAX) cnt[z]++;
            if (it.value != 0 && nzc[z] != CNT_MAX) nzc[z]++;
            wide = sum[z] + it.value;
            if (wide > SUM_MAX) sum[z] = SUM_MAX;
            else if (wide < SUM_MIN) sum[z] = SUM_MIN;
            else sum[z] = wide[63:0];
            if (it.value < mn[z]) mn[z] = it.value;
            if (it.value > mx[z]) mx[z] = it.value;
            return;
        end
        case (sel)
            STAT_SUM:   r.stat_value = sum[z];
            STAT_MEAN:  r.stat_value = (cnt[z] == 0) ? 64'sd0
                                       : sum[z] / $signed({32'd0, cnt[z]});
            STAT_MIN:   r.stat_value = 64'(mn[z]);
            STAT_MAX:   r.stat_value = 64'(mx[z]);
            STAT_COUNT: r.stat_value = {32'd0, cnt[z]};
            STAT_NZ:    r.stat_value = {32'd0, nzc[z]};
            default:    r.stat_value = 64'sd0;
        endcase
        queue_result(r);
    endfunction

    // compare one popped result with the oldest pending one
    function void check_result(t_result got);
        t_result want;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got.stat_value !== want.stat_value || got.is_nodata !== want.is_nodata
            || got.zone_out_of_range !== want.zone_out_of_range) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected val=%0d nd=%b oor=%b, got val=%0d nd=%b oor=%b",
                         want.stat_value, want.is_nodata, want.zone_out_of_range,
                         got.stat_value, got.is_nodata, got.zone_out_of_range);
        end
    endfunction
endclass

module tb_top;
    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_item      i_item;
    logic       empty;
    logic       pop;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    zone_stats_board board;
    bit          calm;      // no idling on either side while set
    int          n_items;

    zonal_statistics_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, transfer when pop and not empty
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_result(o_result);
        pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end

    // push one item, with an optional random gap first; push stays high
    // after the transfer so the next item can follow at once
    task automatic send_item(logic [1:0] kind, logic [15:0] zone, logic [31:0] value);
        while (!calm && $urandom_range(0, 99) < 18) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_item.kind    <= kind;
        i_item.zone_id <= zone;
        i_item.value   <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_item('{kind: kind, zone_id: zone, value: value});
        n_items++;
    endtask

    // let the block drain, then pause for any resultless work in flight
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random item, also of the unused kind or out of range, mostly on a few hot zones
    task automatic random_item();
        logic [1:0]  kind;
        logic [15:0] zone;
        logic [31:0] value;
        int          pick;
        pick = $urandom_range(0, 99);
        kind = (pick < 60) ? KIND_ACC : (pick < 90) ? KIND_LOOK
             : (pick < 96) ? KIND_CLR : 2'd3;
        pick = $urandom_range(0, 99);
        if (pick < 80) zone = 16'($urandom_range(0, 7));
        else if (pick < 92) zone = 16'($urandom_range(0, DEF_NUM_ZONES - 1));
        else zone = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) value = 32'($urandom_range(0, 200000) - 100000);
        else if (pick < 60) value = 32'd0;
        else if (pick < 70) value = board.value_nd;
        else if (pick < 80) value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001;
        else value = $urandom;
        if ($urandom_range(0, 49) == 0) zone = board.zone_nd;
        send_item(kind, zone, value);
    endtask

    initial begin
        logic [2:0] sels [4];
        board       = new();
        calm        = 1'b0;
        n_items     = 0;
        push        = 1'b0;
        pop         = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STAT_SELECT;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty zone, extremes, nodata, out of range, clear
        send_item(KIND_LOOK, 16'd5, 32'd1);
        send_item(KIND_ACC, 16'd0, 32'h7FFF_FFFF);
        send_item(KIND_ACC, 16'd0, 32'h7FFF_FFFF);
        send_item(KIND_ACC, 16'd0, 32'h0);
        send_item(KIND_ACC, 16'd1, 32'h8000_0001);
        send_item(KIND_ACC, 16'd1, 32'h8000_0000);
        send_item(KIND_LOOK, 16'd0, 32'd3);
        send_item(KIND_LOOK, 16'd1, 32'd3);
        send_item(KIND_LOOK, 16'hFFFF, 32'd3);
        send_item(KIND_LOOK, 16'd2, 32'h8000_0000);
        send_item(KIND_ACC, 16'd1024, 32'd7);
        send_item(KIND_LOOK, 16'd1023, 32'd7);
        send_item(KIND_CLR, 16'hFFFF, 32'h8000_0000);
        send_item(KIND_CLR, 16'd2000, 32'd0);
        send_item(2'd3, 16'd0, 32'd0);
        send_item(KIND_CLR, 16'd0, 32'd0);
        send_item(KIND_LOOK, 16'd0, 32'd0);
        drain();

        // mean, min, max and count on zones 1 and 7
        sels = '{STAT_MEAN, STAT_MIN, STAT_MAX, STAT_COUNT};
        foreach (sels[i]) begin
            write_reg(CFG_STAT_SELECT, 32'(sels[i]));
            send_item(KIND_LOOK, 16'd1, 32'd0);
            send_item(KIND_LOOK, 16'd7, 32'd0);
            drain();
        end

        // random phases over several register settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_STAT_SELECT, (ph == 9) ? 32'd7 : 32'(ph % 7));
            write_reg(CFG_ZONE_NODATA, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF
                                       : $urandom_range(0, 15));
            write_reg(CFG_VALUE_NODATA, (ph == 2) ? 32'h7FFF_FFFF
                                        : (ph == 3) ? 32'h8000_0000 : $urandom_range(0, 50));
            calm = (ph == 4);
            for (int k = 0; k < 92; k++) random_item();
            calm = 1'b0;
            drain();
        end

        $display("run covered %0d items and %0d results over all statistics",
                 n_items, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", board.errors,
                     board.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/zse_pkg.sv
hw/rtl/zse_ram.sv
hw/rtl/zse_front.sv
hw/rtl/zse_div.sv
hw/rtl/zse_back.sv
hw/rtl/zonal_statistics_engine.sv
tb/tb_top.sv
